// ----- design/ray_parallelogram_intersection_macros.svh -----
// Assertion macros for the ray/parallelogram intersection block.
// Used by rpi_div and ray_parallelogram_intersection; no dependencies.
`ifndef RAY_PARALLELOGRAM_INTERSECTION_MACROS_SVH
`define RAY_PARALLELOGRAM_INTERSECTION_MACROS_SVH
`ifndef SYNTHESIS
`define RPI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define RPI_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define RPI_ASSERT(lbl, prop, msg)
`define RPI_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- design/rpi_pkg.sv -----
// Shared constants and types for the ray/parallelogram intersection block.
// No dependencies.
package rpi_pkg;
   localparam int DEF_FRAC_BITS   = 10;
   localparam int DEF_COORD_WIDTH = 21;
   localparam int CSR_IDX_W       = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PLANE_NORMAL   = 3'd0,
      CSR_PLANE_OFFSET   = 3'd1,
      CSR_COORD_VECTOR   = 3'd2,
      CSR_CORNER_POINT   = 3'd3,
      CSR_EDGE_U         = 3'd4,
      CSR_EDGE_V         = 3'd5,
      CSR_INFINITE_PLANE = 3'd6,
      CSR_MATERIAL_INDEX = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic neg;
      logic ovf;
   } div_ctl_type;
endpackage

// ----- design/rpi_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with tag pass-through.
// Depends on rpi_pkg and ray_parallelogram_intersection_macros.svh.
`include "ray_parallelogram_intersection_macros.svh"
module rpi_div import rpi_pkg::*; #(
   parameter int DVW  = 55,
   parameter int DSW  = 44,
   parameter int QW   = 22,
   parameter int TAGW = 169
) (
   input  logic              clock,
   input  logic              reset,
   input  div_ctl_type       ctl_in,
   input  logic [DVW-1:0]    dividend_in,
   input  logic [DSW-1:0]    divisor_in,
   input  logic [TAGW-1:0]   tag_in,
   output div_ctl_type       ctl_out,
   output logic [QW-1:0]     quotient_out,
   output logic [TAGW-1:0]   tag_out
);
   localparam int CW = ((DVW > DSW + QW) ? DVW : DSW + QW) + 1;

   div_ctl_type     ctl_ff [QW+1];
   logic [CW-1:0]   rem_ff [QW+1];
   logic [DSW-1:0]  dsr_ff [QW+1];
   logic [QW-1:0]   quo_ff [QW+1];
   logic [TAGW-1:0] tag_ff [QW+1];

   logic [CW-1:0] ovf_lim;
   logic          ovf_in;

   assign ovf_lim = CW'(divisor_in) << QW;
   assign ovf_in  = CW'(dividend_in) >= ovf_lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else begin
         ctl_ff[0] <= '{valid: ctl_in.valid, neg: ctl_in.neg, ovf: ovf_in};
      end
      rem_ff[0] <= CW'(dividend_in);
      dsr_ff[0] <= divisor_in;
      quo_ff[0] <= '0;
      tag_ff[0] <= tag_in;
   end

   for (genvar s = 0; s < QW; s++) begin : g_bit
      localparam int B = QW - 1 - s;
      logic [CW-1:0] shf;
      logic          ge;
      assign shf = CW'(dsr_ff[s]) << B;
      assign ge  = rem_ff[s] >= shf;
      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s+1] <= '0;
         end else begin
            ctl_ff[s+1] <= ctl_ff[s];
         end
         rem_ff[s+1] <= ge ? rem_ff[s] - shf : rem_ff[s];
         dsr_ff[s+1] <= dsr_ff[s];
         quo_ff[s+1] <= {quo_ff[s][QW-2:0], ge};
         tag_ff[s+1] <= tag_ff[s];
      end
   end

   assign ctl_out      = ctl_ff[QW];
   assign quotient_out = quo_ff[QW];
   assign tag_out      = tag_ff[QW];

   `RPI_ASSERT(a_div_rem, (ctl_ff[QW].valid && !ctl_ff[QW].ovf) |-> (rem_ff[QW] < CW'(dsr_ff[QW])), "remainder not below divisor")
   `RPI_ASSERT(a_div_lat, ctl_in.valid |-> ##(QW+1) ctl_out.valid, "divider lost a request")
   `RPI_ASSERT_RST(a_div_rst, reset |=> !ctl_out.valid, "divider valid after reset")
endmodule

// ----- design/ray_parallelogram_intersection.sv -----
// Ray/parallelogram intersection, signed fixed point, fully pipelined.
// Pipeline: stages 1-3, the one-bit-per-stage divider for t, stages 4-10 and the
// output register lie between an accepted request and rsp_valid.
// Throughput: one request per cycle; busy is high only during reset.
// Synchronous reset clears valid bits and restores the default parallelogram.
// Depends on rpi_pkg, rpi_div and ray_parallelogram_intersection_macros.svh.
`include "ray_parallelogram_intersection_macros.svh"
module ray_parallelogram_intersection import rpi_pkg::*; #(
   parameter int FRAC_BITS   = DEF_FRAC_BITS,
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [3*COORD_WIDTH-1:0]      csr_wdata,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_origin_x,
   input  logic signed [COORD_WIDTH-1:0] req_origin_y,
   input  logic signed [COORD_WIDTH-1:0] req_origin_z,
   input  logic signed [COORD_WIDTH-1:0] req_dir_x,
   input  logic signed [COORD_WIDTH-1:0] req_dir_y,
   input  logic signed [COORD_WIDTH-1:0] req_dir_z,
   input  logic signed [COORD_WIDTH-1:0] req_t_min,
   input  logic signed [COORD_WIDTH-1:0] req_t_max,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_t,
   output logic signed [COORD_WIDTH-1:0] rsp_point_x,
   output logic signed [COORD_WIDTH-1:0] rsp_point_y,
   output logic signed [COORD_WIDTH-1:0] rsp_point_z,
   output logic [FRAC_BITS:0]            rsp_coord_a,
   output logic [FRAC_BITS:0]            rsp_coord_b,
   output logic signed [COORD_WIDTH-1:0] rsp_facing_normal_x,
   output logic signed [COORD_WIDTH-1:0] rsp_facing_normal_y,
   output logic signed [COORD_WIDTH-1:0] rsp_facing_normal_z,
   output logic                          rsp_front_face,
   output logic [7:0]                    rsp_hit_material
);
   localparam int W    = COORD_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int VW   = 3 * W;
   localparam int PW   = 2 * W;
   localparam int DENW = 2 * W + 2;
   localparam int NUMW = 2 * W + 3;
   localparam int NW   = NUMW + F;
   localparam int QW   = W + 1;
   localparam int TW   = W + 2;
   localparam int SMW  = PW - F + 1;
   localparam int CPW  = 2 * W + 1;
   localparam int CDW  = 2 * W + 2;
   localparam int CRW  = CDW - F;
   localparam int DPW  = W + CRW;
   localparam int DSW  = DPW + 2;
   localparam int ASW  = DSW - F;
   localparam int ABW  = F + 1;
   localparam int TAGW = 8 * W + 1;
   localparam int LAT  = QW + 12;

   localparam logic signed [W-1:0]   ONE   = W'(1 << F);
   localparam logic signed [W-1:0]   ZERO  = '0;
   localparam logic signed [W-1:0]   MAXW  = W'((1 << (W - 1)) - 1);
   localparam logic signed [W-1:0]   MINW  = -MAXW - W'(1);
   localparam logic signed [SMW-1:0] SMAX  = SMW'(MAXW);
   localparam logic signed [SMW-1:0] SMIN  = SMW'(MINW);
   localparam logic signed [ASW-1:0] AONE  = ASW'(ONE);

   typedef struct packed {
      logic signed [W-1:0] ox;
      logic signed [W-1:0] oy;
      logic signed [W-1:0] oz;
      logic signed [W-1:0] dx;
      logic signed [W-1:0] dy;
      logic signed [W-1:0] dz;
      logic signed [W-1:0] tmin;
      logic signed [W-1:0] tmax;
   } ray_type;

   // configuration
   logic [VW-1:0] n_ff, w_ff, q_ff, u_ff, v_ff;
   logic [W-1:0]  d_ff;
   logic          inf_ff;
   logic [7:0]    mat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff   <= {ZERO, ONE, ZERO};
         d_ff   <= -ONE;
         w_ff   <= {ZERO, ONE, ZERO};
         q_ff   <= {ZERO, -ONE, ZERO};
         u_ff   <= {ZERO, ZERO, ONE};
         v_ff   <= {ONE, ZERO, ZERO};
         inf_ff <= 1'b0;
         mat_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PLANE_NORMAL:   n_ff   <= csr_wdata;
            CSR_PLANE_OFFSET:   d_ff   <= csr_wdata[W-1:0];
            CSR_COORD_VECTOR:   w_ff   <= csr_wdata;
            CSR_CORNER_POINT:   q_ff   <= csr_wdata;
            CSR_EDGE_U:         u_ff   <= csr_wdata;
            CSR_EDGE_V:         v_ff   <= csr_wdata;
            CSR_INFINITE_PLANE: inf_ff <= csr_wdata[0];
            CSR_MATERIAL_INDEX: mat_ff <= csr_wdata[7:0];
         endcase
      end
   end

   logic signed [W-1:0] n_c [3];
   logic signed [W-1:0] w_c [3];
   logic signed [W-1:0] q_c [3];
   logic signed [W-1:0] u_c [3];
   logic signed [W-1:0] v_c [3];
   logic signed [W-1:0] d_c;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_c[i] = $signed(n_ff[(2-i)*W +: W]);
         w_c[i] = $signed(w_ff[(2-i)*W +: W]);
         q_c[i] = $signed(q_ff[(2-i)*W +: W]);
         u_c[i] = $signed(u_ff[(2-i)*W +: W]);
         v_c[i] = $signed(v_ff[(2-i)*W +: W]);
      end
      d_c = $signed(d_ff);
   end

   assign busy = reset;

   // stage 1: plane products
   logic                 s1_v_ff;
   ray_type              s1_ray_ff, ray_in;
   logic signed [PW-1:0] s1_nd_ff [3];
   logic signed [PW-1:0] s1_no_ff [3];
   logic signed [W-1:0]  org_in [3];
   logic signed [W-1:0]  dir_in [3];

   assign org_in[0] = req_origin_x;
   assign org_in[1] = req_origin_y;
   assign org_in[2] = req_origin_z;
   assign dir_in[0] = req_dir_x;
   assign dir_in[1] = req_dir_y;
   assign dir_in[2] = req_dir_z;
   assign ray_in = '{ox: req_origin_x, oy: req_origin_y, oz: req_origin_z,
                     dx: req_dir_x, dy: req_dir_y, dz: req_dir_z,
                     tmin: req_t_min, tmax: req_t_max};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= start && !busy;
      end
      s1_ray_ff <= ray_in;
      for (int i = 0; i < 3; i++) begin
         s1_nd_ff[i] <= PW'(n_c[i]) * PW'(dir_in[i]);
         s1_no_ff[i] <= PW'(n_c[i]) * PW'(org_in[i]);
      end
   end

   // stage 2: denominator and numerator
   logic                   s2_v_ff;
   ray_type                s2_ray_ff;
   logic signed [DENW-1:0] s2_den_ff;
   logic signed [NUMW-1:0] s2_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
      s2_ray_ff <= s1_ray_ff;
      s2_den_ff <= DENW'(s1_nd_ff[0]) + DENW'(s1_nd_ff[1]) + DENW'(s1_nd_ff[2]);
      s2_num_ff <= (NUMW'(d_c) <<< F)
                   - (NUMW'(s1_no_ff[0]) + NUMW'(s1_no_ff[1]) + NUMW'(s1_no_ff[2]));
   end

   // stage 3: magnitudes for the divider
   logic              s3_v_ff, s3_neg_ff, s3_front_ff;
   ray_type           s3_ray_ff;
   logic [NW-1:0]     s3_dvd_ff;
   logic [DENW-1:0]   s3_dsr_ff;
   logic [NUMW-1:0]   num_mag;
   logic [DENW-1:0]   den_mag;

   assign num_mag = s2_num_ff[NUMW-1] ? NUMW'(-s2_num_ff) : NUMW'(s2_num_ff);
   assign den_mag = s2_den_ff[DENW-1] ? DENW'(-s2_den_ff) : DENW'(s2_den_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else begin
         s3_v_ff <= s2_v_ff;
      end
      s3_ray_ff   <= s2_ray_ff;
      s3_neg_ff   <= s2_num_ff[NUMW-1] ^ s2_den_ff[DENW-1];
      s3_front_ff <= s2_den_ff[DENW-1];
      s3_dvd_ff   <= {num_mag, {F{1'b0}}};
      s3_dsr_ff   <= den_mag;
   end

   // divider: t magnitude, overflow also covers a zero denominator
   div_ctl_type     div_ctl_in, div_ctl;
   logic [QW-1:0]   div_quo;
   logic [TAGW-1:0] div_tag;
   ray_type         div_ray;
   logic            div_front;

   assign div_ctl_in = '{valid: s3_v_ff, neg: s3_neg_ff, ovf: 1'b0};

   rpi_div #(
      .DVW  (NW),
      .DSW  (DENW),
      .QW   (QW),
      .TAGW (TAGW)
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .ctl_in       (div_ctl_in),
      .dividend_in  (s3_dvd_ff),
      .divisor_in   (s3_dsr_ff),
      .tag_in       ({s3_ray_ff, s3_front_ff}),
      .ctl_out      (div_ctl),
      .quotient_out (div_quo),
      .tag_out      (div_tag)
   );

   assign {div_ray, div_front} = div_tag;

   // stage 4: signed t
   logic                 s4_v_ff, s4_ovf_ff, s4_front_ff;
   ray_type              s4_ray_ff;
   logic signed [TW-1:0] s4_t_ff;
   logic signed [TW-1:0] t_mag;

   assign t_mag = $signed({1'b0, div_quo});

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else begin
         s4_v_ff <= div_ctl.valid;
      end
      s4_ovf_ff   <= div_ctl.ovf;
      s4_front_ff <= div_front;
      s4_ray_ff   <= div_ray;
      s4_t_ff     <= div_ctl.neg ? -t_mag : t_mag;
   end

   // stage 5: interval test and t * dir
   logic                 s5_v_ff, s5_pass_ff, s5_front_ff;
   logic signed [W-1:0]  s5_t_ff;
   logic signed [W-1:0]  s5_org_ff [3];
   logic signed [PW-1:0] s5_td_ff [3];
   logic signed [W-1:0]  s4_t_w;

   assign s4_t_w = s4_t_ff[W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else begin
         s5_v_ff <= s4_v_ff;
      end
      s5_pass_ff   <= !s4_ovf_ff && (s4_t_ff >= TW'(s4_ray_ff.tmin))
                      && (s4_t_ff <= TW'(s4_ray_ff.tmax));
      s5_front_ff  <= s4_front_ff;
      s5_t_ff      <= s4_t_w;
      s5_org_ff[0] <= s4_ray_ff.ox;
      s5_org_ff[1] <= s4_ray_ff.oy;
      s5_org_ff[2] <= s4_ray_ff.oz;
      s5_td_ff[0]  <= PW'(s4_t_w) * PW'(s4_ray_ff.dx);
      s5_td_ff[1]  <= PW'(s4_t_w) * PW'(s4_ray_ff.dy);
      s5_td_ff[2]  <= PW'(s4_t_w) * PW'(s4_ray_ff.dz);
   end

   // stage 6: saturated hit point
   logic                  s6_v_ff, s6_pass_ff, s6_front_ff;
   logic signed [W-1:0]   s6_t_ff;
   logic signed [W-1:0]   s6_p_ff [3];
   logic signed [SMW-1:0] p_sum [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_sum[i] = SMW'(s5_org_ff[i]) + SMW'($signed(s5_td_ff[i][PW-1:F]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
      end else begin
         s6_v_ff <= s5_v_ff;
      end
      s6_pass_ff  <= s5_pass_ff;
      s6_front_ff <= s5_front_ff;
      s6_t_ff     <= s5_t_ff;
      for (int i = 0; i < 3; i++) begin
         s6_p_ff[i] <= (p_sum[i] > SMAX) ? MAXW :
                       (p_sum[i] < SMIN) ? MINW : p_sum[i][W-1:0];
      end
   end

   // stage 7: point relative to corner
   logic                  s7_v_ff, s7_pass_ff, s7_front_ff;
   logic signed [W-1:0]   s7_t_ff;
   logic signed [W-1:0]   s7_p_ff [3];
   logic signed [W:0]     s7_pl_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_v_ff <= 1'b0;
      end else begin
         s7_v_ff <= s6_v_ff;
      end
      s7_pass_ff  <= s6_pass_ff;
      s7_front_ff <= s6_front_ff;
      s7_t_ff     <= s6_t_ff;
      for (int i = 0; i < 3; i++) begin
         s7_p_ff[i]  <= s6_p_ff[i];
         s7_pl_ff[i] <= (W+1)'(s6_p_ff[i]) - (W+1)'(q_c[i]);
      end
   end

   // stage 8: cross product terms, pl x v and u x pl
   logic                  s8_v_ff, s8_pass_ff, s8_front_ff;
   logic signed [W-1:0]   s8_t_ff;
   logic signed [W-1:0]   s8_p_ff [3];
   logic signed [CPW-1:0] s8_ca_ff [6];
   logic signed [CPW-1:0] s8_cb_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_v_ff <= 1'b0;
      end else begin
         s8_v_ff <= s7_v_ff;
      end
      s8_pass_ff  <= s7_pass_ff;
      s8_front_ff <= s7_front_ff;
      s8_t_ff     <= s7_t_ff;
      for (int i = 0; i < 3; i++) begin
         s8_p_ff[i]      <= s7_p_ff[i];
         s8_ca_ff[2*i]   <= CPW'(s7_pl_ff[(i+1)%3]) * CPW'(v_c[(i+2)%3]);
         s8_ca_ff[2*i+1] <= CPW'(s7_pl_ff[(i+2)%3]) * CPW'(v_c[(i+1)%3]);
         s8_cb_ff[2*i]   <= CPW'(u_c[(i+1)%3]) * CPW'(s7_pl_ff[(i+2)%3]);
         s8_cb_ff[2*i+1] <= CPW'(u_c[(i+2)%3]) * CPW'(s7_pl_ff[(i+1)%3]);
      end
   end

   // stage 9: cross components, floored
   logic                  s9_v_ff, s9_pass_ff, s9_front_ff;
   logic signed [W-1:0]   s9_t_ff;
   logic signed [W-1:0]   s9_p_ff [3];
   logic signed [CRW-1:0] s9_cra_ff [3];
   logic signed [CRW-1:0] s9_crb_ff [3];
   logic signed [CDW-1:0] cra_diff [3];
   logic signed [CDW-1:0] crb_diff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cra_diff[i] = CDW'(s8_ca_ff[2*i]) - CDW'(s8_ca_ff[2*i+1]);
         crb_diff[i] = CDW'(s8_cb_ff[2*i]) - CDW'(s8_cb_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_v_ff <= 1'b0;
      end else begin
         s9_v_ff <= s8_v_ff;
      end
      s9_pass_ff  <= s8_pass_ff;
      s9_front_ff <= s8_front_ff;
      s9_t_ff     <= s8_t_ff;
      for (int i = 0; i < 3; i++) begin
         s9_p_ff[i]   <= s8_p_ff[i];
         s9_cra_ff[i] <= $signed(cra_diff[i][CDW-1:F]);
         s9_crb_ff[i] <= $signed(crb_diff[i][CDW-1:F]);
      end
   end

   // stage 10: dot products with w
   logic                  s10_v_ff, s10_pass_ff, s10_front_ff;
   logic signed [W-1:0]   s10_t_ff;
   logic signed [W-1:0]   s10_p_ff [3];
   logic signed [DPW-1:0] s10_da_ff [3];
   logic signed [DPW-1:0] s10_db_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_v_ff <= 1'b0;
      end else begin
         s10_v_ff <= s9_v_ff;
      end
      s10_pass_ff  <= s9_pass_ff;
      s10_front_ff <= s9_front_ff;
      s10_t_ff     <= s9_t_ff;
      for (int i = 0; i < 3; i++) begin
         s10_p_ff[i]  <= s9_p_ff[i];
         s10_da_ff[i] <= DPW'(w_c[i]) * DPW'(s9_cra_ff[i]);
         s10_db_ff[i] <= DPW'(w_c[i]) * DPW'(s9_crb_ff[i]);
      end
   end

   // output stage
   logic signed [DSW-1:0] a_sum, b_sum;
   logic signed [ASW-1:0] a_val, b_val;
   logic                  ab_ok, hit_in;
   logic signed [W-1:0]   fn_in [3];

   always_comb begin
      a_sum  = DSW'(s10_da_ff[0]) + DSW'(s10_da_ff[1]) + DSW'(s10_da_ff[2]);
      b_sum  = DSW'(s10_db_ff[0]) + DSW'(s10_db_ff[1]) + DSW'(s10_db_ff[2]);
      a_val  = $signed(a_sum[DSW-1:F]);
      b_val  = $signed(b_sum[DSW-1:F]);
      ab_ok  = !a_val[ASW-1] && (a_val <= AONE) && !b_val[ASW-1] && (b_val <= AONE);
      hit_in = s10_v_ff && s10_pass_ff && (inf_ff || ab_ok);
      for (int i = 0; i < 3; i++) begin
         fn_in[i] = s10_front_ff ? n_c[i] : ((n_c[i] == MINW) ? MAXW : -n_c[i]);
      end
   end

   logic                valid_ff, hit_ff, front_ff;
   logic signed [W-1:0] t_ff, px_ff, py_ff, pz_ff, fx_ff, fy_ff, fz_ff;
   logic [ABW-1:0]      ca_ff, cb_ff;
   logic [7:0]          mat_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= s10_v_ff;
         hit_ff   <= hit_in;
      end
      t_ff       <= hit_in ? s10_t_ff : ZERO;
      px_ff      <= hit_in ? s10_p_ff[0] : ZERO;
      py_ff      <= hit_in ? s10_p_ff[1] : ZERO;
      pz_ff      <= hit_in ? s10_p_ff[2] : ZERO;
      ca_ff      <= (hit_in && !inf_ff) ? a_val[ABW-1:0] : '0;
      cb_ff      <= (hit_in && !inf_ff) ? b_val[ABW-1:0] : '0;
      fx_ff      <= hit_in ? fn_in[0] : ZERO;
      fy_ff      <= hit_in ? fn_in[1] : ZERO;
      fz_ff      <= hit_in ? fn_in[2] : ZERO;
      front_ff   <= hit_in && s10_front_ff;
      mat_out_ff <= hit_in ? mat_ff : '0;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_hit             = hit_ff;
   assign rsp_hit_t           = t_ff;
   assign rsp_point_x         = px_ff;
   assign rsp_point_y         = py_ff;
   assign rsp_point_z         = pz_ff;
   assign rsp_coord_a         = ca_ff;
   assign rsp_coord_b         = cb_ff;
   assign rsp_facing_normal_x = fx_ff;
   assign rsp_facing_normal_y = fy_ff;
   assign rsp_facing_normal_z = fz_ff;
   assign rsp_front_face      = front_ff;
   assign rsp_hit_material    = mat_out_ff;

   `RPI_ASSERT(a_latency, (start && !busy) |-> ##LAT rsp_valid, "request produced no response")
   `RPI_ASSERT(a_coord_range, (rsp_hit && !inf_ff) |-> ((rsp_coord_a <= ABW'(ONE)) && (rsp_coord_b <= ABW'(ONE))), "hit outside parallelogram")
   `RPI_ASSERT(a_miss_zero, (rsp_valid && !rsp_hit) |-> ((rsp_hit_t == ZERO) && (rsp_hit_material == 8'd0) && !rsp_front_face), "miss with nonzero fields")
   `RPI_ASSERT_RST(a_reset, reset |=> (!rsp_valid && !rsp_hit), "response after reset")
endmodule

// ----- sim/ray_parallelogram_intersection_checker.sv -----
// Checker for ray_parallelogram_intersection: mirrors the register file, predicts the
// hit record of every accepted request and compares each response in order.
// Depends on rpi_pkg.
module ray_parallelogram_intersection_checker import rpi_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [62:0]             csr_wdata,
   input  logic                    start,
   input  logic                    busy,
   input  logic signed [20:0]      req_origin_x,
   input  logic signed [20:0]      req_origin_y,
   input  logic signed [20:0]      req_origin_z,
   input  logic signed [20:0]      req_dir_x,
   input  logic signed [20:0]      req_dir_y,
   input  logic signed [20:0]      req_dir_z,
   input  logic signed [20:0]      req_t_min,
   input  logic signed [20:0]      req_t_max,
   input  logic                    rsp_valid,
   input  logic                    rsp_hit,
   input  logic signed [20:0]      rsp_hit_t,
   input  logic signed [20:0]      rsp_point_x,
   input  logic signed [20:0]      rsp_point_y,
   input  logic signed [20:0]      rsp_point_z,
   input  logic [10:0]             rsp_coord_a,
   input  logic [10:0]             rsp_coord_b,
   input  logic signed [20:0]      rsp_facing_normal_x,
   input  logic signed [20:0]      rsp_facing_normal_y,
   input  logic signed [20:0]      rsp_facing_normal_z,
   input  logic                    rsp_front_face,
   input  logic [7:0]              rsp_hit_material,
   output int                      outstanding,
   output int                      failures
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = DEF_COORD_WIDTH;
   localparam int F = DEF_FRAC_BITS;
   localparam longint CMAX = (64'sd1 <<< (W-1)) - 1;
   localparam longint CMIN = -CMAX - 1;

   typedef struct packed {
      logic              hit;
      logic signed [20:0] t;
      logic signed [20:0] px;
      logic signed [20:0] py;
      logic signed [20:0] pz;
      logic [10:0]        a;
      logic [10:0]        b;
      logic signed [20:0] nx;
      logic signed [20:0] ny;
      logic signed [20:0] nz;
      logic               front;
      logic [7:0]         mat;
   } hit_record_type;

   logic [62:0] normal_ff, coord_ff, corner_ff, eu_ff, ev_ff;
   logic [20:0] offset_ff;
   logic        inf_ff;
   logic [7:0]  mat_ff;
   hit_record_type pending_hits[$];

   assign outstanding = pending_hits.size();

   function automatic longint comp(logic [62:0] vec, int i);
      logic signed [20:0] s;
      s = vec[(2-i)*W +: W];
      return s;
   endfunction

   function automatic longint clamp(longint x);
      return x > CMAX ? CMAX : (x < CMIN ? CMIN : x);
   endfunction

   function automatic hit_record_type trace_ray(longint org[3], longint dir[3],
                                                longint tmin, longint tmax);
      longint n[3], w[3], q[3], u[3], v[3], p[3], pl[3], cr[3], fn[3];
      longint d, den, num, t, a, b, one;
      hit_record_type r;
      r = '0;
      one = 64'sd1 <<< F;
      a = 0;
      b = 0;
      for (int i = 0; i < 3; i++) begin
         n[i] = comp(normal_ff, i);
         w[i] = comp(coord_ff, i);
         q[i] = comp(corner_ff, i);
         u[i] = comp(eu_ff, i);
         v[i] = comp(ev_ff, i);
      end
      d = longint'($signed(offset_ff));
      den = n[0]*dir[0] + n[1]*dir[1] + n[2]*dir[2];
      if (den == 0) return r;
      num = d*one - (n[0]*org[0] + n[1]*org[1] + n[2]*org[2]);
      t = (num*one) / den;
      if (t < tmin || t > tmax) return r;
      for (int i = 0; i < 3; i++) p[i] = clamp(org[i] + ((t*dir[i]) >>> F));
      if (!inf_ff) begin
         for (int i = 0; i < 3; i++) pl[i] = p[i] - q[i];
         cr[0] = (pl[1]*v[2] - pl[2]*v[1]) >>> F;
         cr[1] = (pl[2]*v[0] - pl[0]*v[2]) >>> F;
         cr[2] = (pl[0]*v[1] - pl[1]*v[0]) >>> F;
         a = (w[0]*cr[0] + w[1]*cr[1] + w[2]*cr[2]) >>> F;
         cr[0] = (u[1]*pl[2] - u[2]*pl[1]) >>> F;
         cr[1] = (u[2]*pl[0] - u[0]*pl[2]) >>> F;
         cr[2] = (u[0]*pl[1] - u[1]*pl[0]) >>> F;
         b = (w[0]*cr[0] + w[1]*cr[1] + w[2]*cr[2]) >>> F;
         if (a < 0 || a > one || b < 0 || b > one) return r;
      end
      for (int i = 0; i < 3; i++) fn[i] = (den < 0) ? n[i] : clamp(-n[i]);
      r.hit   = 1'b1;
      r.t     = t[20:0];
      r.px    = p[0][20:0];
      r.py    = p[1][20:0];
      r.pz    = p[2][20:0];
      r.a     = a[10:0];
      r.b     = b[10:0];
      r.nx    = fn[0][20:0];
      r.ny    = fn[1][20:0];
      r.nz    = fn[2][20:0];
      r.front = (den < 0);
      r.mat   = mat_ff;
      return r;
   endfunction

   always @(posedge clock) begin
      longint org[3], dir[3];
      hit_record_type got, want;
      if (reset) begin
         normal_ff <= {21'd0, 21'd1024, 21'd0};
         offset_ff <= -21'sd1024;
         coord_ff  <= {21'd0, 21'd1024, 21'd0};
         corner_ff <= {21'd0, -21'sd1024, 21'd0};
         eu_ff     <= {21'd0, 21'd0, 21'd1024};
         ev_ff     <= {21'd1024, 21'd0, 21'd0};
         inf_ff    <= 1'b0;
         mat_ff    <= 8'd0;
         pending_hits.delete();
      end else begin
         if (start && !busy) begin
            org[0] = req_origin_x; org[1] = req_origin_y; org[2] = req_origin_z;
            dir[0] = req_dir_x;    dir[1] = req_dir_y;    dir[2] = req_dir_z;
            pending_hits.push_back(trace_ray(org, dir, req_t_min, req_t_max));
         end
         if (rsp_valid) begin
            got = {rsp_hit, rsp_hit_t, rsp_point_x, rsp_point_y, rsp_point_z,
                   rsp_coord_a, rsp_coord_b, rsp_facing_normal_x, rsp_facing_normal_y,
                   rsp_facing_normal_z, rsp_front_face, rsp_hit_material};
            if (pending_hits.size() == 0) begin
               failures <= failures + 1;
               if (failures < 10) $display("unexpected response %p", got);
            end else begin
               want = pending_hits.pop_front();
               if (got !== want) begin
                  failures <= failures + 1;
                  if (failures < 10) $display("mismatch\n  exp %p\n  got %p", want, got);
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PLANE_NORMAL:   normal_ff <= csr_wdata;
               CSR_PLANE_OFFSET:   offset_ff <= csr_wdata[20:0];
               CSR_COORD_VECTOR:   coord_ff  <= csr_wdata;
               CSR_CORNER_POINT:   corner_ff <= csr_wdata;
               CSR_EDGE_U:         eu_ff     <= csr_wdata;
               CSR_EDGE_V:         ev_ff     <= csr_wdata;
               CSR_INFINITE_PLANE: inf_ff    <= csr_wdata[0];
               CSR_MATERIAL_INDEX: mat_ff    <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
   end

   initial failures = 0;
endmodule

// ----- sim/tb_ray_parallelogram_intersection.sv -----
// Testbench top for ray_parallelogram_intersection: resets, programs the parallelogram
// in phases and streams directed and random rays; the checker judges responses.
// Depends on rpi_pkg, the block and ray_parallelogram_intersection_checker.
module tb_ray_parallelogram_intersection;
   import rpi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ONE = 1024;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [62:0] csr_wdata = '0;
   logic start = 1'b0;
   logic busy;
   logic signed [20:0] ox = '0, oy = '0, oz = '0, dx = '0, dy = '0, dz = '0;
   logic signed [20:0] tmin = '0, tmax = '0;
   logic rsp_valid, rsp_hit, rsp_front_face;
   logic signed [20:0] rsp_hit_t, rsp_point_x, rsp_point_y, rsp_point_z;
   logic signed [20:0] rsp_fnx, rsp_fny, rsp_fnz;
   logic [10:0] rsp_coord_a, rsp_coord_b;
   logic [7:0] rsp_hit_material;
   int outstanding, failures, idle_pct;
   longint aim_q[3], aim_u[3], aim_v[3];

   always #5 clock = ~clock;

   ray_parallelogram_intersection i_dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .start(start), .busy(busy),
      .req_origin_x(ox), .req_origin_y(oy), .req_origin_z(oz),
      .req_dir_x(dx), .req_dir_y(dy), .req_dir_z(dz),
      .req_t_min(tmin), .req_t_max(tmax),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_hit_t(rsp_hit_t),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y), .rsp_point_z(rsp_point_z),
      .rsp_coord_a(rsp_coord_a), .rsp_coord_b(rsp_coord_b),
      .rsp_facing_normal_x(rsp_fnx), .rsp_facing_normal_y(rsp_fny),
      .rsp_facing_normal_z(rsp_fnz), .rsp_front_face(rsp_front_face),
      .rsp_hit_material(rsp_hit_material)
   );

   ray_parallelogram_intersection_checker i_checker (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .start(start), .busy(busy),
      .req_origin_x(ox), .req_origin_y(oy), .req_origin_z(oz),
      .req_dir_x(dx), .req_dir_y(dy), .req_dir_z(dz),
      .req_t_min(tmin), .req_t_max(tmax),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_hit_t(rsp_hit_t),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y), .rsp_point_z(rsp_point_z),
      .rsp_coord_a(rsp_coord_a), .rsp_coord_b(rsp_coord_b),
      .rsp_facing_normal_x(rsp_fnx), .rsp_facing_normal_y(rsp_fny),
      .rsp_facing_normal_z(rsp_fnz), .rsp_front_face(rsp_front_face),
      .rsp_hit_material(rsp_hit_material),
      .outstanding(outstanding), .failures(failures)
   );

   function automatic logic [62:0] pack3(longint x, longint y, longint z);
      logic [20:0] a, b, c;
      a = x[20:0]; b = y[20:0]; c = z[20:0];
      return {a, b, c};
   endfunction

   function automatic longint srand(longint lim);
      return longint'($urandom_range(2*lim)) - lim;
   endfunction

   task automatic idle_cycle();
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic send_ray(longint x, longint y, longint z, longint a, longint b,
                           longint c, longint lo, longint hi);
      while ($urandom_range(99) < idle_pct) idle_cycle();
      @(negedge clock);
      start <= 1'b1;
      ox <= x[20:0]; oy <= y[20:0]; oz <= z[20:0];
      dx <= a[20:0]; dy <= b[20:0]; dz <= c[20:0];
      tmin <= lo[20:0]; tmax <= hi[20:0];
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      idle_cycle();
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [62:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // axis-aligned unit-edge parallelogram, random corner and orientation
   task automatic load_square(bit inf);
      int k, s;
      longint n[3];
      k = $urandom_range(2);
      s = $urandom_range(1) ? 1 : -1;
      for (int i = 0; i < 3; i++) begin
         aim_q[i] = srand(4*ONE);
         n[i] = 0; aim_u[i] = 0; aim_v[i] = 0;
      end
      n[k] = s*ONE;
      aim_u[(k+1)%3] = ($urandom_range(3) != 0) ? ONE : -ONE;
      aim_v[(k+2)%3] = ($urandom_range(3) != 0) ? ONE : -ONE;
      drain();
      write_csr(CSR_PLANE_NORMAL, pack3(n[0], n[1], n[2]));
      write_csr(CSR_PLANE_OFFSET, pack3(0, 0, s*aim_q[k]));
      write_csr(CSR_COORD_VECTOR, pack3(n[0], n[1], n[2]));
      write_csr(CSR_CORNER_POINT, pack3(aim_q[0], aim_q[1], aim_q[2]));
      write_csr(CSR_EDGE_U, pack3(aim_u[0], aim_u[1], aim_u[2]));
      write_csr(CSR_EDGE_V, pack3(aim_v[0], aim_v[1], aim_v[2]));
      write_csr(CSR_INFINITE_PLANE, 63'(inf));
      write_csr(CSR_MATERIAL_INDEX, 63'($urandom_range(255)));
   endtask

   task automatic load_raw(bit extreme);
      drain();
      if (extreme) begin
         write_csr(CSR_PLANE_NORMAL, pack3(-(ONE << 10), 0, (ONE << 10) - 1));
         write_csr(CSR_PLANE_OFFSET, {42'd0, 21'h100000});
         write_csr(CSR_COORD_VECTOR, {63{1'b1}});
         write_csr(CSR_CORNER_POINT, pack3((ONE << 10) - 1, -(ONE << 10), 0));
         write_csr(CSR_EDGE_U, pack3((ONE << 10) - 1, (ONE << 10) - 1, (ONE << 10) - 1));
         write_csr(CSR_EDGE_V, pack3(-(ONE << 10), -(ONE << 10), -(ONE << 10)));
         write_csr(CSR_INFINITE_PLANE, 63'(1));
         write_csr(CSR_MATERIAL_INDEX, 63'(8'hff));
      end else begin
         for (int i = 0; i < 8; i++)
            write_csr(csr_index_type'(i), 63'({$urandom, $urandom}));
      end
   endtask

   task automatic aimed_ray();
      longint p[3], o[3], lo, hi, al, be;
      al = srand(ONE/2 + 100) + ONE/2;
      be = srand(ONE/2 + 100) + ONE/2;
      for (int i = 0; i < 3; i++) begin
         p[i] = aim_q[i] + (al*aim_u[i] + be*aim_v[i]) / ONE;
         o[i] = p[i] + srand(4*ONE);
      end
      if ($urandom_range(4) == 0) begin
         lo = -(ONE << 10); hi = (ONE << 10) - 1;
      end else begin
         lo = srand(2*ONE) - ONE;
         hi = ONE + longint'($urandom_range(3*ONE));
      end
      send_ray(o[0], o[1], o[2], p[0]-o[0], p[1]-o[1], p[2]-o[2], lo, hi);
   endtask

   task automatic noise_ray();
      send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom);
   endtask

   initial begin
      int pct[5];
      pct = '{0, 72, 0, 72, 29};
      idle_pct = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default square: plane y = -1, a follows z and b follows x
      send_ray(ONE/2, ONE, ONE/2, 0, -ONE, 0, 0, 4*ONE);
      send_ray(0, ONE, 0, 0, -ONE, 0, 0, 4*ONE);
      send_ray(ONE, ONE, ONE, 0, -ONE, 0, 0, 4*ONE);
      send_ray(ONE+1, ONE, ONE/2, 0, -ONE, 0, 0, 4*ONE);
      send_ray(ONE/2, ONE, -1, 0, -ONE, 0, 0, 4*ONE);
      send_ray(ONE/2, -2*ONE, ONE/2, 0, ONE, 0, 0, 4*ONE);
      send_ray(ONE/2, ONE, ONE/2, ONE, 0, 0, 0, 4*ONE);
      send_ray(ONE/2, ONE, ONE/2, 0, -ONE, 0, 2*ONE, 2*ONE);
      send_ray(ONE/2, ONE, ONE/2, 0, -ONE, 0, 2*ONE+1, 4*ONE);
      send_ray(ONE/2, ONE, ONE/2, 0, -ONE, 0, 0, 2*ONE-1);
      send_ray(ONE/2, ONE, ONE/2, 0, -ONE, 0, 3*ONE, ONE);
      send_ray(-(ONE << 10), (ONE << 10) - 1, -(ONE << 10), 1, -1, 1,
               -(ONE << 10), (ONE << 10) - 1);
      send_ray((ONE << 10) - 1, -(ONE << 10), (ONE << 10) - 1, -(ONE << 10),
               (ONE << 10) - 1, -(ONE << 10), -(ONE << 10), (ONE << 10) - 1);
      send_ray(0, 0, 0, 0, 0, 0, -(ONE << 10), (ONE << 10) - 1);
      load_raw(1'b1);
      send_ray(ONE, 0, 0, -1, 0, 0, -(ONE << 10), (ONE << 10) - 1);
      send_ray(ONE, 0, 0, 1, 0, 0, -(ONE << 10), (ONE << 10) - 1);
      send_ray(-(ONE << 10), 0, 0, ONE, 0, 0, -(ONE << 10), (ONE << 10) - 1);
      load_square(1'b1);
      repeat (6) aimed_ray();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            2: load_raw(1'b0);
            3: load_raw(1'b1);
            default: load_square($urandom_range(3) == 0);
         endcase
         idle_pct = pct[ph];
         for (int k = 0; k < 345; k++) begin
            if (k == 170) begin
               drain();
               if (ph == 1) load_square(1'b0);
            end
            if ($urandom_range(4) == 0) noise_ray();
            else aimed_ray();
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("tb: failure");
      $finish;
   end
endmodule
